### rtl/core/qamnp_pkg.sv
// Package for the QAM nearest-point demapper: default sizes, register map,
// constellation level codes and per-axis decision codes. No dependencies.
package qamnp_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF    = 12;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;
   localparam int INDEX_W    = 4;

   localparam logic [REG_IDX_W-1:0] REG_LEVEL_SELECT = '0;

   typedef enum logic {
      LEVEL_QAM4  = 1'b0,
      LEVEL_QAM16 = 1'b1
   } level_type;

   // In-phase level code, in table order of the 16-QAM points
   localparam logic [1:0] I_P3 = 2'd0;
   localparam logic [1:0] I_P1 = 2'd1;
   localparam logic [1:0] I_M1 = 2'd2;
   localparam logic [1:0] I_M3 = 2'd3;

   // Quadrature code: {negative half, row within half}
   localparam logic [1:0] Q_P3 = 2'b00;
   localparam logic [1:0] Q_P1 = 2'b01;
   localparam logic [1:0] Q_M3 = 2'b10;
   localparam logic [1:0] Q_M1 = 2'b11;

endpackage

### rtl/core/qam_nearest_point_demapper.sv
// QAM nearest-point hard-decision demapper, 4-QAM or 16-QAM.
// Depends on qamnp_pkg.
//
//  channel    ports                                   flow control
//  request    start, busy, req_in_phase, req_quadrature   start while busy low
//  result     rsp_strobe, rsp_point_index             one-cycle strobe, no stall
//  csr        psel, penable, pwrite, paddr, pwdata,   pready tied high
//             prdata, pready
//
// One request per clock. Each request goes through the input register, then
// per-axis threshold decision into the result register. busy stays low.
// Synchronous reset clears the valid bits and level_select.
module qam_nearest_point_demapper #(
   parameter int SAMPLE_WIDTH = qamnp_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = qamnp_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_in_phase,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_quadrature,
   output logic                                   rsp_strobe,
   output logic [qamnp_pkg::INDEX_W-1:0]          rsp_point_index,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [qamnp_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [qamnp_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [qamnp_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                   pready
);
   import qamnp_pkg::*;

   localparam int CmpWidth =
      ((SAMPLE_WIDTH > FRAC_BITS + 2) ? SAMPLE_WIDTH : FRAC_BITS + 2) + 1;
   localparam logic signed [CmpWidth-1:0] TwoScale = CmpWidth'(1) << (FRAC_BITS + 1);
   localparam logic signed [CmpWidth-1:0] NegTwoScale = -TwoScale;

   level_type                     level_ff, level_in;
   logic                          valid1_ff, valid1_in;
   level_type                     level1_ff, level1_in;
   logic signed [SAMPLE_WIDTH-1:0] in_phase_ff, in_phase_in;
   logic signed [SAMPLE_WIDTH-1:0] quadrature_ff, quadrature_in;
   logic                          strobe_ff, strobe_in;
   level_type                     level2_ff, level2_in;
   logic [INDEX_W-1:0]            index_ff, index_in;

   logic                          accept;
   logic                          reg_hit;
   logic signed [CmpWidth-1:0]    ext_i, ext_q;
   logic [1:0]                    code_i, code_q;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign pready = 1'b1;

   // configuration
   assign reg_hit = (paddr[CSR_ADDR_W-1:2] == REG_LEVEL_SELECT);

   always_comb begin
      level_in = level_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         level_in = level_type'(pwdata[0]);
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_hit) begin
         prdata[0] = level_ff;
      end
   end

   // input register
   assign valid1_in     = accept;
   assign level1_in     = accept ? level_ff : level1_ff;
   assign in_phase_in   = accept ? req_in_phase : in_phase_ff;
   assign quadrature_in = accept ? req_quadrature : quadrature_ff;

   // per-axis decision, ties resolved toward the lower table index
   assign ext_i = signed'({{(CmpWidth-SAMPLE_WIDTH){in_phase_ff[SAMPLE_WIDTH-1]}},
                           in_phase_ff});
   assign ext_q = signed'({{(CmpWidth-SAMPLE_WIDTH){quadrature_ff[SAMPLE_WIDTH-1]}},
                           quadrature_ff});

   always_comb begin
      if (ext_i >= TwoScale) begin
         code_i = I_P3;
      end else if (ext_i >= 0) begin
         code_i = I_P1;
      end else if (ext_i >= NegTwoScale) begin
         code_i = I_M1;
      end else begin
         code_i = I_M3;
      end
   end

   always_comb begin
      if (ext_q >= TwoScale) begin
         code_q = Q_P3;
      end else if (ext_q >= 0) begin
         code_q = Q_P1;
      end else if (ext_q > NegTwoScale) begin
         code_q = Q_M1;
      end else begin
         code_q = Q_M3;
      end
   end

   always_comb begin
      case (level1_ff)
         LEVEL_QAM16: index_in = {code_q[1], code_i, code_q[0]};
         LEVEL_QAM4:  index_in = {2'b00, in_phase_ff[SAMPLE_WIDTH-1],
                                  quadrature_ff[SAMPLE_WIDTH-1]};
         default:     index_in = '0;
      endcase
   end

   assign strobe_in = valid1_ff;
   assign level2_in = level1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= LEVEL_QAM4;
         valid1_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         level_ff  <= level_in;
         valid1_ff <= valid1_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      level1_ff     <= level1_in;
      in_phase_ff   <= in_phase_in;
      quadrature_ff <= quadrature_in;
      level2_ff     <= level2_in;
      index_ff      <= index_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_point_index = index_ff;

   // checks
   a_strobe_follows_request: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("request produced no result");

   a_no_spurious_result: assert property (@(posedge clock)
      rsp_strobe |-> $past(accept, 2))
      else $error("result without request");

   a_qam4_quadrant: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (level2_ff == LEVEL_QAM4) |->
         (rsp_point_index[3:2] == 2'b00) &&
         (rsp_point_index[1] == $past(req_in_phase[SAMPLE_WIDTH-1], 2)) &&
         (rsp_point_index[0] == $past(req_quadrature[SAMPLE_WIDTH-1], 2)))
      else $error("4-QAM index does not match sample quadrant");

endmodule
